// File: design/clhp_pkg.sv
// ----------------------------------------------------------------------------
// clhp_pkg
// Types, character constants and per-byte header line logic shared by the
// content-length header parser.
// ----------------------------------------------------------------------------
package clhp_pkg;

    localparam int unsigned LEN_W = 63;

    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_SP      = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CASE_FOLD  = 8'h20;

    localparam logic [3:0] KEY_LEN = 4'd14;

    // "content-length", padded to a power-of-two depth
    localparam logic [7:0] KEY_TEXT [16] = '{
        8'h63, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
        8'h6C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h00, 8'h00
    };

    localparam logic [LEN_W-1:0] VAL_MAX = {LEN_W{1'b1}};

    typedef enum logic [1:0] {
        SEC_REQLINE = 2'd0,
        SEC_HEADERS = 2'd1,
        SEC_DONE    = 2'd2
    } t_section;

    typedef enum logic [1:0] {
        PH_LEAD  = 2'd0,
        PH_MID   = 2'd1,
        PH_TRAIL = 2'd2,
        PH_FAIL  = 2'd3
    } t_phase;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_byte_item;

    typedef struct packed {
        logic             line_is_empty;
        logic             colon_seen;
        t_phase           key_phase;
        logic [3:0]       key_match_pos;
        t_phase           value_phase;
        logic [LEN_W-1:0] accumulator;
    } t_line;

    localparam t_line LINE_CLEAR = '{
        line_is_empty: 1'b1,
        colon_seen:    1'b0,
        key_phase:     PH_LEAD,
        key_match_pos: 4'd0,
        value_phase:   PH_LEAD,
        accumulator:   '0
    };

    function automatic logic is_ws(logic [7:0] b);
        return (b == CH_SP) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
    endfunction

    // One content byte of a header line. Once the answer is decided only the
    // empty-line flag still moves.
    function automatic t_line line_byte(t_line s, logic decided, logic [7:0] b);
        t_line          r;
        logic [7:0]     c;
        logic           ws;
        logic           digit;
        logic [LEN_W+3:0] prod;
        r     = s;
        r.line_is_empty = 1'b0;
        c     = ((b >= CH_UPPER_A) && (b <= CH_UPPER_Z)) ? (b + CASE_FOLD) : b;
        ws    = is_ws(b);
        digit = (b >= CH_DIGIT_0) && (b <= CH_DIGIT_9);
        // acc*10 + digit; bits above the 63rd flag saturation
        prod  = ({4'b0, s.accumulator} << 3) + ({4'b0, s.accumulator} << 1)
              + {{LEN_W{1'b0}}, b[3:0]};
        if (!decided) begin
            if (!s.colon_seen) begin
                if (b == CH_COLON) begin
                    r.colon_seen = 1'b1;
                end else if (ws) begin
                    if (s.key_phase == PH_MID) r.key_phase = PH_TRAIL;
                end else if ((s.key_phase == PH_LEAD || s.key_phase == PH_MID) &&
                             (s.key_match_pos < KEY_LEN) &&
                             (c == KEY_TEXT[s.key_match_pos])) begin
                    r.key_match_pos = s.key_match_pos + 4'd1;
                    r.key_phase     = PH_MID;
                end else begin
                    r.key_phase = PH_FAIL;
                end
            end else begin
                if (ws) begin
                    if (s.value_phase == PH_MID) r.value_phase = PH_TRAIL;
                end else if (digit &&
                             (s.value_phase == PH_LEAD || s.value_phase == PH_MID)) begin
                    r.accumulator = (prod[LEN_W+3:LEN_W] != 4'd0) ? VAL_MAX
                                                                 : prod[LEN_W-1:0];
                    r.value_phase = PH_MID;
                end else begin
                    r.value_phase = PH_FAIL;
                end
            end
        end
        return r;
    endfunction

endpackage

// File: design/clhp_in_stage.sv
// ----------------------------------------------------------------------------
// clhp_in_stage
// Input register: holds one byte transaction until the parse core takes it.
// ----------------------------------------------------------------------------
module clhp_in_stage
    import clhp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_byte_item i_item,
    output logic       o_item_valid,
    output t_byte_item o_item,
    input  logic       i_take
);

    logic       r_valid;
    t_byte_item r_item;

    assign o_ready      = !r_valid || i_take;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// File: design/clhp_core.sv
// ----------------------------------------------------------------------------
// clhp_core
// Parse state and result register: one byte per cycle updates the section, line
// and answer state; the last byte loads the result, once its register is free.
// ----------------------------------------------------------------------------
module clhp_core
    import clhp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_item_valid,
    input  t_byte_item       i_item,
    output logic             o_take,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [LEN_W-1:0] o_content_length
);

    t_section         r_section,  n_section;
    logic             r_cr,       n_cr;
    t_line            r_line,     n_line;
    logic             r_decided,  n_decided;
    logic [LEN_W-1:0] r_value,    n_value;
    logic             r_out_valid;
    logic [LEN_W-1:0] r_out_len;
    logic [LEN_W-1:0] w_result;
    logic [7:0]       w_b;

    // a last byte needs a free result register
    assign o_take = i_item_valid && (!i_item.last || !r_out_valid || i_ready);
    assign w_b    = i_item.data;

    // next state
    always_comb begin
        t_section sec;
        logic     cr;
        t_line    ln;
        logic     dec;
        logic [LEN_W-1:0] val;
        sec = r_section;
        cr  = r_cr;
        ln  = r_line;
        dec = r_decided;
        val = r_value;
        if (sec != SEC_DONE) begin
            if (cr && w_b == CH_LF) begin
                cr = 1'b0;
                if (sec == SEC_REQLINE) begin
                    sec = SEC_HEADERS;
                    ln  = LINE_CLEAR;
                end else if (ln.line_is_empty) begin
                    sec = SEC_DONE;
                end else begin
                    if (!dec && ln.colon_seen && ln.key_match_pos == KEY_LEN &&
                        (ln.key_phase == PH_MID || ln.key_phase == PH_TRAIL)) begin
                        dec = 1'b1;
                        val = (ln.value_phase == PH_MID || ln.value_phase == PH_TRAIL)
                            ? ln.accumulator : '0;
                    end
                    ln = LINE_CLEAR;
                end
            end else begin
                // a CR not followed by LF is plain whitespace of the line
                if (cr && sec == SEC_HEADERS) ln = line_byte(ln, dec, CH_CR);
                if (w_b == CH_CR) begin
                    cr = 1'b1;
                end else begin
                    cr = 1'b0;
                    if (sec == SEC_HEADERS) ln = line_byte(ln, dec, w_b);
                end
            end
        end
        n_section = sec;
        n_cr      = cr;
        n_line    = ln;
        n_decided = dec;
        n_value   = val;
    end

    // result of the request, valid when its last byte is taken
    always_comb begin
        case (n_section)
            SEC_DONE: w_result = n_decided ? n_value : '0;
            default:  w_result = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_section <= SEC_REQLINE;
            r_cr      <= 1'b0;
            r_line    <= LINE_CLEAR;
            r_decided <= 1'b0;
            r_value   <= '0;
        end else if (o_take) begin
            if (i_item.last) begin
                r_section <= SEC_REQLINE;
                r_cr      <= 1'b0;
                r_line    <= LINE_CLEAR;
                r_decided <= 1'b0;
                r_value   <= '0;
            end else begin
                r_section <= n_section;
                r_cr      <= n_cr;
                r_line    <= n_line;
                r_decided <= n_decided;
                r_value   <= n_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take && i_item.last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_item.last) begin
            r_out_len <= w_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_content_length = r_out_len;

endmodule

// File: design/content_length_header_parser.sv
// ----------------------------------------------------------------------------
// content_length_header_parser
// Streams request bytes and reports the Content-Length value on the last byte.
// Throughput: one byte per cycle while the result register can take a last byte;
//   the parse state is registered as each byte is taken. A last byte passes the
//   input register, then the result register, before the result is valid.
// Reset: synchronous active low; clears parse state and both valid flags.
// ----------------------------------------------------------------------------
module content_length_header_parser
    import clhp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_req_byte,
    input  logic             i_is_last,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [LEN_W-1:0] o_content_length
);

    t_byte_item w_in_item;
    t_byte_item w_item;
    logic       w_item_valid;
    logic       w_take;

    assign w_in_item.data = i_req_byte;
    assign w_in_item.last = i_is_last;

    clhp_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_item       (w_in_item),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_take       (w_take)
    );

    clhp_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item_valid     (w_item_valid),
        .i_item           (w_item),
        .o_take           (w_take),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_content_length (o_content_length)
    );

    a_take_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> w_item_valid)
        else $error("core took a byte from an empty input register");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && w_item.last |=> o_valid)
        else $error("last byte taken without a result");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_item_valid && w_item.last && o_valid && !i_ready |-> !w_take)
        else $error("pending result overwritten");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for content_length_header_parser. Whole requests are
// streamed one byte per transaction with random gaps on both handshakes. A
// byte-level tracker follows the parse and queues the length each request
// must report, and every result is compared against the oldest entry.
// ---------------------------------------------------------------------------
module testbench;
    import clhp_pkg::*;

    localparam int                     CYCLE_LIMIT  = 600000;
    localparam int                     DRAIN_CYCLES = 16;
    localparam int                     RANDOM_BYTES = 1300;
    localparam int                     KEY_CHARS    = 14;
    localparam logic [8*KEY_CHARS-1:0] KEY_WORD     = "content-length";
    localparam logic [63:0]            LENGTH_CAP   = 64'h7FFF_FFFF_FFFF_FFFF;
    // directed text uses these marks for CR and LF
    localparam logic [7:0]             MARK_CR      = "^";
    localparam logic [7:0]             MARK_LF      = "~";

    class content_length_tracker;
        t_section         sect;
        logic             cr_held;
        logic             line_blank;
        logic             colon;
        logic             have_answer;
        t_phase           key_ph;
        t_phase           val_ph;
        int unsigned      key_pos;
        logic [63:0]      acc;
        logic [63:0]      answer;
        logic [LEN_W-1:0] due_lengths[$];
        int               failures;

        function new();
            failures = 0;
            restart();
        endfunction

        function void fresh_line();
            line_blank = 1'b1;
            colon      = 1'b0;
            key_ph     = PH_LEAD;
            key_pos    = 0;
            val_ph     = PH_LEAD;
            acc        = '0;
        endfunction

        function void restart();
            sect        = SEC_REQLINE;
            cr_held     = 1'b0;
            have_answer = 1'b0;
            answer      = '0;
            fresh_line();
        endfunction

        function logic is_blank(logic [7:0] b);
            return b == CH_SP || b == CH_TAB || b == CH_CR || b == CH_LF;
        endfunction

        function void key_char(logic [7:0] b);
            logic [7:0] lc;
            lc = (b >= CH_UPPER_A && b <= CH_UPPER_Z) ? b + CASE_FOLD : b;
            if (is_blank(b)) begin
                if (key_ph == PH_MID) key_ph = PH_TRAIL;
            end else if ((key_ph == PH_LEAD || key_ph == PH_MID) && key_pos < KEY_CHARS &&
                         lc == KEY_WORD[8*(KEY_CHARS-1-key_pos) +: 8]) begin
                key_pos++;
                key_ph = PH_MID;
            end else begin
                key_ph = PH_FAIL;
            end
        endfunction

        function void value_char(logic [7:0] b);
            logic [63:0] d;
            d = {56'd0, b - CH_DIGIT_0};
            if (is_blank(b)) begin
                if (val_ph == PH_MID) val_ph = PH_TRAIL;
            end else if (b >= CH_DIGIT_0 && b <= CH_DIGIT_9 &&
                         (val_ph == PH_LEAD || val_ph == PH_MID)) begin
                if (acc <= (LENGTH_CAP - d) / 10) acc = acc * 10 + d;
                else acc = LENGTH_CAP;
                val_ph = PH_MID;
            end else begin
                val_ph = PH_FAIL;
            end
        endfunction

        function void line_char(logic [7:0] b);
            line_blank = 1'b0;
            if (have_answer) return;
            if (!colon) begin
                if (b == CH_COLON) colon = 1'b1;
                else key_char(b);
            end else begin
                value_char(b);
            end
        endfunction

        function void close_line();
            if (!have_answer && colon && key_pos == KEY_CHARS &&
                (key_ph == PH_MID || key_ph == PH_TRAIL)) begin
                have_answer = 1'b1;
                answer      = (val_ph == PH_MID || val_ph == PH_TRAIL) ? acc : '0;
            end
            fresh_line();
        endfunction

        // called once per accepted input transaction
        function void take_byte(logic [7:0] b, logic is_last_byte);
            if (sect != SEC_DONE) begin
                if (cr_held && b == CH_LF) begin
                    cr_held = 1'b0;
                    if (sect == SEC_REQLINE) begin
                        sect = SEC_HEADERS;
                        fresh_line();
                    end else if (line_blank) begin
                        sect = SEC_DONE;
                    end else begin
                        close_line();
                    end
                end else begin
                    // a CR not followed by LF is plain line content
                    if (cr_held && sect == SEC_HEADERS) line_char(CH_CR);
                    if (b == CH_CR) begin
                        cr_held = 1'b1;
                    end else begin
                        cr_held = 1'b0;
                        if (sect == SEC_HEADERS) line_char(b);
                    end
                end
            end
            if (is_last_byte) begin
                due_lengths.insert(due_lengths.size(), (sect == SEC_DONE && have_answer) ?
                                   answer[LEN_W-1:0] : '0);
                restart();
            end
        endfunction

        function void compare_length(logic [LEN_W-1:0] got);
            logic [LEN_W-1:0] want;
            if (due_lengths.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: content_length %0d", got);
            end else begin
                want = due_lengths.pop_front();
                if (got !== want) begin
                    failures++;
                    if (failures <= 10)
                        $display("content_length mismatch: expected %0d, got %0d", want, got);
                end
            end
        endfunction
    endclass

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_valid    = 1'b0;
    logic             o_ready;
    logic [7:0]       i_req_byte = '0;
    logic             i_is_last  = 1'b0;
    logic             o_valid;
    logic             i_ready    = 1'b0;
    logic [LEN_W-1:0] o_content_length;

    content_length_tracker tracker = new();
    logic [7:0] req_bytes[$];
    logic       calm        = 1'b0;
    int         stall_left  = 0;
    int         cycle_count = 0;
    int         random_sent = 0;

    content_length_header_parser dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_req_byte       (i_req_byte),
        .i_is_last        (i_is_last),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_content_length (o_content_length)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic int pick_gap();
        if (calm || $urandom_range(0, 99) >= 30) return 0;
        return idle_len();
    endfunction

    // result side: check, then choose ready for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) tracker.compare_length(o_content_length);
        if (stall_left > 0) begin
            i_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            i_ready <= 1'b1;
            if (!calm && $urandom_range(0, 99) < 25) stall_left <= idle_len();
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // valid stays high after a transaction unless a gap follows
    task automatic push_byte(input logic [7:0] b, input logic is_last_byte);
        int gap;
        i_valid    <= 1'b1;
        i_req_byte <= b;
        i_is_last  <= is_last_byte;
        do @(posedge i_clk); while (!o_ready);
        tracker.take_byte(b, is_last_byte);
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_request();
        for (int i = 0; i < req_bytes.size(); i++)
            push_byte(req_bytes[i], i == req_bytes.size() - 1);
        req_bytes.delete();
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.due_lengths.size() != 0) @(posedge i_clk);
    endtask

    function automatic void add_byte(logic [7:0] b);
        req_bytes.insert(req_bytes.size(), b);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            if (s[i] == MARK_CR) add_byte(CH_CR);
            else if (s[i] == MARK_LF) add_byte(CH_LF);
            else add_byte(s[i]);
        end
    endfunction

    task automatic send_text(string s);
        add_text(s);
        send_request();
    endtask

    function automatic void add_crlf();
        add_byte(CH_CR);
        add_byte(CH_LF);
    endfunction

    function automatic logic [7:0] any_case(logic [7:0] c);
        if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) return c - CASE_FOLD;
        return c;
    endfunction

    function automatic void add_spaces(int max_n);
        int r;
        repeat ($urandom_range(0, max_n)) begin
            r = $urandom_range(0, 19);
            add_byte(r < 12 ? CH_SP : r < 18 ? CH_TAB : r == 18 ? CH_CR : CH_LF);
        end
    endfunction

    function automatic void add_digits(int n);
        repeat (n) add_byte(8'($urandom_range(CH_DIGIT_0, CH_DIGIT_9)));
    endfunction

    function automatic void add_noise(int n);
        repeat (n) add_byte(8'($urandom_range(0, 255)));
    endfunction

    function automatic void add_length_line();
        logic [7:0] c;
        add_spaces(2);
        for (int i = 0; i < KEY_CHARS; i++) begin
            c = KEY_WORD[8*(KEY_CHARS-1-i) +: 8];
            if ($urandom_range(0, 39) == 0) c = 8'($urandom_range(8'h21, 8'h7E));
            add_byte(any_case(c));
        end
        add_spaces(2);
        add_byte(CH_COLON);
        add_spaces(2);
        case ($urandom_range(0, 9))
            0: ;
            1: begin
                add_digits($urandom_range(1, 3));
                add_byte(8'($urandom_range(8'h21, 8'h7E)));
                add_digits($urandom_range(0, 3));
            end
            2: add_digits($urandom_range(19, 24));
            3: begin
                add_digits($urandom_range(1, 3));
                add_byte(CH_SP);
                add_digits($urandom_range(1, 3));
            end
            default: add_digits($urandom_range(1, 12));
        endcase
        add_spaces(2);
        add_crlf();
    endfunction

    function automatic void add_other_line();
        int r;
        repeat ($urandom_range(1, 10)) begin
            r = $urandom_range(0, 26);
            add_byte(r == 26 ? 8'h2D : any_case(8'("a" + r)));
        end
        if ($urandom_range(0, 7) != 0) add_byte(CH_COLON);
        add_spaces(2);
        repeat ($urandom_range(0, 10)) add_byte(8'($urandom_range(8'h20, 8'h7E)));
        add_crlf();
    endfunction

    // mostly well-formed requests with random content, some pure noise
    function automatic void build_random_request();
        int r;
        if ($urandom_range(0, 9) == 0) begin
            add_noise($urandom_range(1, 30));
        end else begin
            repeat ($urandom_range(0, 8)) add_byte(8'($urandom_range(8'h20, 8'h7E)));
            add_crlf();
            repeat ($urandom_range(0, 4)) begin
                r = $urandom_range(0, 19);
                if (r < 9) add_length_line();
                else if (r < 17) add_other_line();
                else add_noise($urandom_range(1, 6));
            end
            r = $urandom_range(0, 19);
            if (r < 17) add_crlf();
            else if (r == 17) add_byte(CH_CR);
            if ($urandom_range(0, 3) == 0) add_noise($urandom_range(1, 8));
        end
        if (req_bytes.size() == 0) add_noise(1);
    endfunction

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_text("GET / HTTP/1.1^~Content-Length: 42^~^~");
        send_text("POST /x HTTP/1.1^~Host: a^~content-LENGTH:\t 7 \t^~^~trailing body");
        send_text("^~Content-Length:^~^~");
        send_text("^~Content-Length: 1a2^~^~");
        send_text("^~Content-Length: 1 2^~^~");
        send_text("^~X-A: 1^~Content-Length: 5^~Content-Length: 9^~^~");
        send_text("^~Content-Length: 5^~");
        send_text("^~Content-Length: 8^~^");
        send_text("^~Content-Length: 9223372036854775807^~^~");
        send_text("^~Content-Length: 9223372036854775808^~^~");
        send_text("^~Content-Length: 000123456789012345678901234^~^~");
        send_text("^~Content-Length:^ 3^~^~");
        send_text("^~Content^-Length: 3^~^~");
        send_text("^~Content-Length: 3~^~^~");
        send_text("Content-Length: 4^~^~");
        send_text("^~  cOnTeNt-LeNgTh \t: 12^~^~");
        send_text("^~content-lengthx: 1^~^~");
        send_text("^~content-len: 1^~^~");
        send_text("^~: 1^~Content-Length 6^~Content-Length: 0^~Content-Length: 6^~^~");
        send_text("^^~^~");
        send_text("^~^~Content-Length: 3^~^~");
        add_byte(8'h00);
        send_request();
        add_byte(8'hFF);
        send_request();
        wait_for_results();

        while (random_sent < RANDOM_BYTES) begin
            build_random_request();
            random_sent += req_bytes.size();
            calm <= ($urandom_range(0, 6) == 0);
            if ($urandom_range(0, 11) == 0) wait_for_results();
            send_request();
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.failures == 0 && tracker.due_lengths.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
